// ===== sv/cled_pkg.sv =====
// Shared types and character constants for the C literal escape decoder.
package cled_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_ESC,
		PH_HEX,
		PH_OCT
	} phase_t;

	typedef enum logic [2:0] {
		K_BYTE,
		K_STR_END,
		K_CHAR_VAL,
		K_NOT_LIT,
		K_UNTERM
	} res_kind_t;

	typedef enum logic [2:0] {
		AL_NONE,
		AL_UNKNOWN_ESC,
		AL_EMPTY_HEX,
		AL_HEX_RANGE,
		AL_OCT_RANGE,
		AL_MULTIBYTE,
		AL_EMPTY_CHAR
	} alert_t;

	typedef struct packed {
		logic [31:0] value;
		res_kind_t   kind;
		alert_t      alert;
		logic        last;
	} result_t;

	// one queue entry: all results caused by one input byte
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    has2;
	} entry_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_rd_t;

	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_QMARK     = 8'h3F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] ASCII_NL     = 8'd10;
	localparam logic [7:0] ASCII_CR     = 8'd13;
	localparam logic [7:0] ASCII_TAB    = 8'd9;
	localparam logic [7:0] ASCII_VT     = 8'd11;
	localparam logic [7:0] ASCII_FF     = 8'd12;
	localparam logic [7:0] ASCII_BEL    = 8'd7;
	localparam logic [7:0] ASCII_BS     = 8'd8;
	localparam logic [7:0] ASCII_ESC    = 8'h1B;

endpackage

// ===== sv/cled_if.sv =====
// Stream interfaces: source bytes in, decoded results out.
interface cled_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source(output valid, output byte_in, input ready);
	modport sink(input valid, input byte_in, output ready);
endinterface

interface cled_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic [2:0]  kind;
	logic [2:0]  alert;
	logic        last;

	modport source(output valid, output value, output kind, output alert, output last,
		input ready);
	modport sink(input valid, input value, input kind, input alert, input last,
		output ready);
endinterface

// ===== sv/cled_front.sv =====
// Front end: literal state machine, decodes one byte per beat into up to two results.
module cled_front import cled_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	cled_byte_if.sink     byte_stream,
	output q_wr_t         qwr,
	input  logic          q_full,
	output entry_t        entry
);

	phase_t      phase_q, phase_d;
	logic [8:0]  esc_q, esc_d;     // 9 bits: octal range check, hex keeps low byte
	logic [1:0]  dcnt_q, dcnt_d;
	logic [31:0] cacc_q, cacc_d;
	logic [1:0]  ccnt_q, ccnt_d;
	logic        literal_kind_q;

	logic        accept;
	logic [7:0]  b;
	logic [7:0]  quote;
	logic        is_oct;
	logic [4:0]  hexd;

	logic        dlv;
	logic [7:0]  dlv_byte;
	alert_t      dlv_alert;
	logic        do_body;
	logic        pre_v, body_v;
	result_t     pre_res, body_res;
	logic [7:0]  se_val;
	alert_t      se_alert;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic void simple_esc(input logic [7:0] c, output logic [7:0] v,
		output alert_t a);
		v = c;
		a = AL_NONE;
		unique case (c)
			CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BACKSLASH: v = c;
			8'h61: v = ASCII_BEL;
			8'h62: v = ASCII_BS;
			8'h66: v = ASCII_FF;
			8'h6E: v = ASCII_NL;
			8'h72: v = ASCII_CR;
			8'h74: v = ASCII_TAB;
			8'h76: v = ASCII_VT;
			8'h65: v = ASCII_ESC;
			default: a = AL_UNKNOWN_ESC;
		endcase
	endfunction

	assign b                 = byte_stream.byte_in;
	assign byte_stream.ready = !q_full;
	assign accept            = byte_stream.valid && !q_full;
	assign quote             = literal_kind_q ? CH_SQUOTE : CH_DQUOTE;
	assign is_oct            = (b[7:3] == 5'b00110);
	assign hexd              = hex_digit(b);

	always_comb begin
		phase_d   = phase_q;
		esc_d     = esc_q;
		dcnt_d    = dcnt_q;
		cacc_d    = cacc_q;
		ccnt_d    = ccnt_q;
		dlv       = 1'b0;
		dlv_byte  = '0;
		dlv_alert = AL_NONE;
		do_body   = 1'b0;
		pre_v     = 1'b0;
		pre_res   = '0;
		body_v    = 1'b0;
		body_res  = '0;
		se_val    = '0;
		se_alert  = AL_NONE;

		unique case (phase_q)
			PH_BODY: do_body = 1'b1;
			PH_ESC: begin
				if (b == CH_X) begin
					esc_d   = '0;
					dcnt_d  = '0;
					phase_d = PH_HEX;
				end else if (is_oct) begin
					esc_d   = {6'b0, b[2:0]};
					dcnt_d  = 2'd1;
					phase_d = PH_OCT;
				end else begin
					simple_esc(b, se_val, se_alert);
					phase_d   = PH_BODY;
					dlv       = 1'b1;
					dlv_byte  = se_val;
					dlv_alert = se_alert;
				end
			end
			PH_HEX: begin
				if (hexd[4]) begin
					esc_d = {esc_q[4:0], hexd[3:0]};
					if (dcnt_q != 2'd3)
						dcnt_d = dcnt_q + 2'd1;
				end else begin
					phase_d  = PH_BODY;
					dlv      = 1'b1;
					dlv_byte = esc_q[7:0];
					if (dcnt_q == 2'd0)
						dlv_alert = AL_EMPTY_HEX;
					else if (dcnt_q == 2'd3)
						dlv_alert = AL_HEX_RANGE;
					do_body = 1'b1;
				end
			end
			PH_OCT: begin
				if (is_oct && dcnt_q != 2'd3) begin
					esc_d  = {esc_q[5:0], b[2:0]};
					dcnt_d = dcnt_q + 2'd1;
					if (dcnt_q == 2'd2) begin
						phase_d   = PH_BODY;
						dlv       = 1'b1;
						dlv_byte  = esc_d[7:0];
						dlv_alert = esc_d[8] ? AL_OCT_RANGE : AL_NONE;
					end
				end else begin
					phase_d   = PH_BODY;
					dlv       = 1'b1;
					dlv_byte  = esc_q[7:0];
					dlv_alert = esc_q[8] ? AL_OCT_RANGE : AL_NONE;
					do_body   = 1'b1;
				end
			end
			default: begin
				if (b == quote) begin
					phase_d = PH_BODY;
					esc_d   = '0;
					dcnt_d  = '0;
					cacc_d  = '0;
					ccnt_d  = '0;
				end else begin
					phase_d        = PH_IDLE;
					pre_v          = 1'b1;
					pre_res.kind   = K_NOT_LIT;
				end
			end
		endcase

		if (dlv) begin
			pre_v         = 1'b1;
			pre_res.value = {24'b0, dlv_byte};
			pre_res.kind  = K_BYTE;
			pre_res.alert = dlv_alert;
			if (literal_kind_q) begin
				cacc_d = {cacc_d[23:0], dlv_byte};
				if (ccnt_d != 2'd2)
					ccnt_d = ccnt_d + 2'd1;
			end
		end

		if (do_body) begin
			priority if (b == quote) begin
				body_v  = 1'b1;
				phase_d = PH_IDLE;
				if (!literal_kind_q) begin
					body_res.kind = K_STR_END;
				end else if (ccnt_d == 2'd0) begin
					body_res.kind  = K_CHAR_VAL;
					body_res.alert = AL_EMPTY_CHAR;
				end else begin
					body_res.kind  = K_CHAR_VAL;
					body_res.value = cacc_d;
					body_res.alert = (ccnt_d == 2'd2) ? AL_MULTIBYTE : AL_NONE;
				end
			end else if (b == ASCII_NL || b == CH_NUL) begin
				body_v        = 1'b1;
				phase_d       = PH_IDLE;
				body_res.kind = K_UNTERM;
			end else if (b == CH_BACKSLASH) begin
				phase_d = PH_ESC;
			end else begin
				body_v         = 1'b1;
				body_res.value = {24'b0, b};
				body_res.kind  = K_BYTE;
				if (literal_kind_q) begin
					cacc_d = {cacc_d[23:0], b};
					if (ccnt_d != 2'd2)
						ccnt_d = ccnt_d + 2'd1;
				end
			end
		end
	end

	assign qwr.push   = accept && (pre_v || body_v);
	assign qwr.full   = q_full;
	assign entry.has2 = pre_v && body_v;
	assign entry.r0   = pre_v ? pre_res : body_res;
	assign entry.r1   = body_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			esc_q          <= '0;
			dcnt_q         <= '0;
			cacc_q         <= '0;
			ccnt_q         <= '0;
			literal_kind_q <= 1'b0;
		end else begin
			if (cfg_we)
				literal_kind_q <= cfg_wdata;
			if (accept) begin
				phase_q <= phase_d;
				esc_q   <= esc_d;
				dcnt_q  <= dcnt_d;
				cacc_q  <= cacc_d;
				ccnt_q  <= ccnt_d;
			end
		end
	end

endmodule

// ===== sv/cled_queue.sv =====
// Short FIFO of decoded entries between the front and back ends.
module cled_queue import cled_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  q_wr_t  qwr,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output q_rd_t  qrd,
	output entry_t rd_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign qrd.empty = (count_q == '0);
	assign qrd.pop   = do_pop;
	assign do_push   = qwr.push && !qwr.full;
	assign do_pop    = pop && !qrd.empty;
	assign rd_entry  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/cled_back.sv =====
// Back end: splits each entry into result beats behind an output register.
module cled_back import cled_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  q_rd_t        qrd,
	input  entry_t       rd_entry,
	output logic         pop,
	cled_result_if.source result_stream
);

	result_t out_q, pend_res_q;
	logic    out_valid_q, pend_q;
	logic    load;

	assign load = !out_valid_q || result_stream.ready;
	assign pop  = load && !pend_q && !qrd.empty;

	assign result_stream.valid = out_valid_q;
	assign result_stream.value = out_q.value;
	assign result_stream.kind  = out_q.kind;
	assign result_stream.alert = out_q.alert;
	assign result_stream.last  = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (qrd.pop) begin
				out_valid_q <= 1'b1;
				pend_q      <= rd_entry.has2;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q <= pend_res_q;
			end else if (qrd.pop) begin
				out_q      <= '{value: rd_entry.r0.value, kind: rd_entry.r0.kind,
					alert: rd_entry.r0.alert, last: !rd_entry.has2};
				pend_res_q <= '{value: rd_entry.r1.value, kind: rd_entry.r1.kind,
					alert: rd_entry.r1.alert, last: 1'b1};
			end
		end
	end

endmodule

// ===== sv/c_literal_escape_decoder_unit.sv =====
// Top level of the C literal escape decoder: front end, entry queue, back end.
//
//   channel        dir  handshake        payload
//   byte_stream    in   valid/ready      byte_in[7:0]
//   result_stream  out  valid/ready      value[31:0] kind[2:0] alert[2:0] last
//   cfg            in   cfg_we           cfg_wdata (literal kind)
//
// One byte per cycle is taken while the queue has room; the front end decodes it in the accept cycle.
// A byte that causes two results leaves the back end as two result beats; the
// entry queue (QUEUE_DEPTH entries) absorbs that, so input stalls only when it fills.
// Input ready drops only on a full queue; output stalls back up through the queue.
// Reset clears the literal state, queue pointers and output valid; no clearing pass.
module c_literal_escape_decoder_unit import cled_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	cled_byte_if.sink     byte_stream,
	cled_result_if.source result_stream
);

	q_wr_t  qwr;
	q_rd_t  qrd;
	entry_t wr_entry, rd_entry;
	logic   q_full;
	logic   pop;

	cled_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.byte_stream (byte_stream),
		.qwr         (qwr),
		.q_full      (q_full),
		.entry       (wr_entry)
	);

	cled_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.qwr      (qwr),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.qrd      (qrd),
		.rd_entry (rd_entry)
	);

	cled_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.qrd           (qrd),
		.rd_entry      (rd_entry),
		.pop           (pop),
		.result_stream (result_stream)
	);

endmodule

// ===== sim/cled_checker.sv =====
// Decoder checker: predicts results from accepted bytes and compares each result beat.
module cled_checker import cled_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic [7:0]  byte_in,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [31:0] res_value,
	input  logic [2:0]  res_kind,
	input  logic [2:0]  res_alert,
	input  logic        res_last,
	output int          errors,
	output int          pending
);

	// predicted decoder state
	logic        lit_char;
	phase_t      ph;
	logic [31:0] esc_acc;
	logic [1:0]  esc_digits;
	logic [31:0] chr_acc;
	logic [1:0]  chr_cnt;

	result_t     step_res[$];
	result_t     expected[$];
	int          mismatches;

	function automatic logic [7:0] quote_char();
		return lit_char ? CH_SQUOTE : CH_DQUOTE;
	endfunction

	function automatic logic is_octal(input logic [7:0] b);
		return b >= "0" && b <= "7";
	endfunction

	function automatic int hex_digit(input logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	task automatic add_result(input logic [31:0] v, input res_kind_t k, input alert_t a);
		step_res.push_back('{value: v, kind: k, alert: a, last: 1'b0});
	endtask

	// a decoded byte also feeds the packed char value in char mode
	task automatic put_decoded(input logic [7:0] b, input alert_t a);
		if (lit_char) begin
			chr_acc = {chr_acc[23:0], b};
			if (chr_cnt < 2)
				chr_cnt++;
		end
		add_result({24'd0, b}, K_BYTE, a);
	endtask

	task automatic body_char(input logic [7:0] b);
		if (b == quote_char()) begin
			if (!lit_char)
				add_result(32'd0, K_STR_END, AL_NONE);
			else if (chr_cnt == 0)
				add_result(32'd0, K_CHAR_VAL, AL_EMPTY_CHAR);
			else
				add_result(chr_acc, K_CHAR_VAL, chr_cnt > 1 ? AL_MULTIBYTE : AL_NONE);
			ph = PH_IDLE;
		end else if (b == ASCII_NL || b == CH_NUL) begin
			add_result(32'd0, K_UNTERM, AL_NONE);
			ph = PH_IDLE;
		end else if (b == CH_BACKSLASH) begin
			ph = PH_ESC;
		end else begin
			put_decoded(b, AL_NONE);
		end
	endtask

	task automatic simple_escape(input logic [7:0] b);
		logic [7:0] v;
		alert_t     a;
		v = b;
		a = AL_NONE;
		case (b)
			CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BACKSLASH: ;
			"a": v = ASCII_BEL;
			"b": v = ASCII_BS;
			"f": v = ASCII_FF;
			"n": v = ASCII_NL;
			"r": v = ASCII_CR;
			"t": v = ASCII_TAB;
			"v": v = ASCII_VT;
			"e": v = ASCII_ESC;
			default: a = AL_UNKNOWN_ESC;
		endcase
		ph = PH_BODY;
		put_decoded(v, a);
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int     d;
		alert_t a;
		step_res.delete();
		case (ph)
			PH_BODY: body_char(b);
			PH_ESC: begin
				if (b == CH_X) begin
					esc_acc = '0;
					esc_digits = '0;
					ph = PH_HEX;
				end else if (is_octal(b)) begin
					esc_acc = {29'd0, b[2:0]};
					esc_digits = 2'd1;
					ph = PH_OCT;
				end else begin
					simple_escape(b);
				end
			end
			PH_HEX: begin
				d = hex_digit(b);
				if (d >= 0) begin
					esc_acc = {esc_acc[27:0], 4'(d)};
					if (esc_digits < 3)
						esc_digits++;
				end else begin
					// terminating byte is reprocessed as a body byte
					a = AL_NONE;
					if (esc_digits == 0)
						a = AL_EMPTY_HEX;
					else if (esc_digits > 2)
						a = AL_HEX_RANGE;
					ph = PH_BODY;
					put_decoded(esc_acc[7:0], a);
					body_char(b);
				end
			end
			PH_OCT: begin
				if (is_octal(b) && esc_digits < 3) begin
					esc_acc = {esc_acc[28:0], b[2:0]};
					esc_digits++;
					if (esc_digits >= 3) begin
						ph = PH_BODY;
						put_decoded(esc_acc[7:0], esc_acc > 32'd255 ? AL_OCT_RANGE : AL_NONE);
					end
				end else begin
					ph = PH_BODY;
					put_decoded(esc_acc[7:0], esc_acc > 32'd255 ? AL_OCT_RANGE : AL_NONE);
					body_char(b);
				end
			end
			default: begin
				if (b == quote_char()) begin
					ph = PH_BODY;
					esc_acc = '0;
					esc_digits = '0;
					chr_acc = '0;
					chr_cnt = '0;
				end else begin
					ph = PH_IDLE;
					add_result(32'd0, K_NOT_LIT, AL_NONE);
				end
			end
		endcase
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			expected.push_back(step_res[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			lit_char = 1'b0;
			ph = PH_IDLE;
			esc_acc = '0;
			esc_digits = '0;
			chr_acc = '0;
			chr_cnt = '0;
			expected.delete();
			mismatches = 0;
		end else begin
			if (cfg_we)
				lit_char = cfg_wdata;
			if (byte_valid && byte_ready)
				decode_byte(byte_in);
			if (res_valid && res_ready) begin
				if (expected.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected: value=%h kind=%0d alert=%0d last=%b",
						$time, res_value, res_kind, res_alert, res_last);
				end else begin
					want = expected.pop_front();
					if (res_value !== want.value || res_kind !== want.kind ||
							res_alert !== want.alert || res_last !== want.last) begin
						mismatches++;
						$display("%0t: expected value=%h kind=%0d alert=%0d last=%b",
							$time, want.value, want.kind, want.alert, want.last);
						$display("%0t:   actual value=%h kind=%0d alert=%0d last=%b",
							$time, res_value, res_kind, res_alert, res_last);
					end
				end
			end
		end
		errors <= mismatches;
		pending <= expected.size();
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top: byte stimulus, result backpressure, watchdog and verdict.
module tb;
	import cled_pkg::*;

	localparam int RANDOM_ITEMS   = 650;
	localparam int SETTLE         = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	cled_byte_if   byte_ch();
	cled_result_if res_ch();

	int errors;
	int pending;
	int bytes_sent   = 0;
	int quiet_cycles = 0;
	int gap_odds     = 4;
	int stall_odds   = 4;
	logic calm       = 1'b0;

	c_literal_escape_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_stream(byte_ch),
		.result_stream(res_ch)
	);

	cled_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_valid(byte_ch.valid),
		.byte_ready(byte_ch.ready),
		.byte_in(byte_ch.byte_in),
		.res_valid(res_ch.valid),
		.res_ready(res_ch.ready),
		.res_value(res_ch.value),
		.res_kind(res_ch.kind),
		.res_alert(res_ch.alert),
		.res_last(res_ch.last),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result sink: stall bursts unless calm
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send(input logic [7:0] b);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_in <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// no beat left in flight, and bytes without a result given time to clear the front end
	task automatic drain_block();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_kind(input logic char_mode);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= char_mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] body_filler(input logic [7:0] q);
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == q || b == CH_BACKSLASH || b == ASCII_NL || b == CH_NUL);
		return b;
	endfunction

	function automatic logic [7:0] escape_letter();
		string      simple;
		logic [7:0] b;
		simple = "'\"?\\abfnrtve";
		if ($urandom_range(0, 2) != 0)
			return simple[$urandom_range(0, simple.len() - 1)];
		// anything that does not open a numeric escape
		do
			b = 8'($urandom);
		while (b == CH_X || (b >= "0" && b <= "7"));
		return b;
	endfunction

	function automatic logic [7:0] hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, digits.len() - 1)];
	endfunction

	task automatic send_literal(input logic char_mode);
		logic [7:0] q;
		int         parts;
		int         sel;
		q = char_mode ? CH_SQUOTE : CH_DQUOTE;
		send(q);
		parts = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
		repeat (parts) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0, 1, 2, 3: send(body_filler(q));
				4, 5: begin
					send(CH_BACKSLASH);
					send(escape_letter());
				end
				6, 7: begin
					send(CH_BACKSLASH);
					send(CH_X);
					repeat ($urandom_range(0, 4)) send(hex_char());
				end
				default: begin
					send(CH_BACKSLASH);
					repeat ($urandom_range(1, 3)) send(8'("0" + $urandom_range(0, 7)));
				end
			endcase
		end
		sel = $urandom_range(0, 15);
		if (sel == 0)
			send(ASCII_NL);
		else if (sel == 1)
			send(CH_NUL);
		else
			send(q);
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 4;
			default: return 12;
		endcase
	endfunction

	initial begin
		logic [7:0] str_cases[$];
		logic [7:0] chr_cases[$];
		int         random_goal;
		int         segment_end;
		int         n_segment;
		logic       char_mode;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.byte_in <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// stray byte while idle, \e, long hex, octal overflow, empty hex before the quote,
		// newline ending an octal escape, backslash-NUL and NUL in the body
		str_cases = '{8'hFF, CH_DQUOTE, CH_BACKSLASH, "e", CH_BACKSLASH, CH_X, "a", "b", "c",
			"g", CH_BACKSLASH, "7", "7", "7", CH_BACKSLASH, CH_X, CH_DQUOTE,
			CH_DQUOTE, CH_BACKSLASH, "0", ASCII_NL,
			CH_DQUOTE, CH_BACKSLASH, CH_NUL, CH_NUL};
		// empty char literal, then a multibyte one
		chr_cases = '{CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, "a", "b", CH_SQUOTE};

		set_kind(1'b0);
		foreach (str_cases[i])
			send(str_cases[i]);
		set_kind(1'b1);
		foreach (chr_cases[i])
			send(chr_cases[i]);

		random_goal = bytes_sent + RANDOM_ITEMS;
		n_segment = 0;
		while (bytes_sent < random_goal) begin
			char_mode = n_segment[0];
			set_kind(char_mode);
			gap_odds = pick_odds();
			stall_odds = pick_odds();
			segment_end = bytes_sent + $urandom_range(30, 90);
			while (bytes_sent < segment_end && bytes_sent < random_goal) begin
				if (bytes_sent >= random_goal - 60)
					calm = 1'b1;
				if ($urandom_range(0, 7) != 0)
					send_literal(char_mode);
				else
					repeat ($urandom_range(1, 3)) send(8'($urandom));
			end
			n_segment++;
		end

		calm = 1'b1;
		drain_block();
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/cled_pkg.sv
sv/cled_if.sv
sv/cled_front.sv
sv/cled_queue.sv
sv/cled_back.sv
sv/c_literal_escape_decoder_unit.sv
sim/cled_checker.sv
sim/tb.sv
